// ===== src/tpl_pkg.sv =====
// tpl_pkg: shared types and constants of the triangle point locator
// field widths, item mode codes and the sign unit status struct
// no dependencies
package tpl_pkg;

	// fixed field widths of the items
	localparam int MODE_W   = 2;
	localparam int SLOT_W   = 8;
	localparam int COORD_W  = 16;
	localparam int CORNER_W = 8;
	localparam int COUNT_W  = 9;
	localparam int TIDX_W   = 8;

	// item mode codes
	localparam logic [MODE_W-1:0] MODE_LOAD_VERTEX   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_TRIANGLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY         = 2'd2;

	// status returned by the cross product sign unit
	typedef struct packed {
		logic done;
		logic neg;
		logic pos;
	} tpl_cross_stat_t;

endpackage

// ===== src/tpl_item_if.sv =====
// tpl_item_if: input item channel of the triangle point locator
// depends on tpl_pkg for field widths
interface tpl_item_if import tpl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic [SLOT_W-1:0]          slot;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;
	logic [CORNER_W-1:0]        corner_a;
	logic [CORNER_W-1:0]        corner_b;
	logic [CORNER_W-1:0]        corner_c;

	modport source (output valid, mode, slot, coord_x, coord_y, corner_a, corner_b, corner_c,
		input ready);
	modport sink (input valid, mode, slot, coord_x, coord_y, corner_a, corner_b, corner_c,
		output ready);
endinterface

// ===== src/tpl_result_if.sv =====
// tpl_result_if: result item channel of the triangle point locator
// depends on tpl_pkg for field widths
interface tpl_result_if import tpl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	logic [TIDX_W-1:0] triangle_index;

	modport source (output valid, found, triangle_index, input ready);
	modport sink (input valid, found, triangle_index, output ready);
endinterface

// ===== src/tpl_cfg_if.sv =====
// tpl_cfg_if: configuration write channel carrying triangle_count
// depends on tpl_pkg for the register width
interface tpl_cfg_if import tpl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== src/tpl_cross_unit.sv =====
// tpl_cross_unit: shared sign unit for one edge cross product (p-r)x(q-r)
// one multiplier used twice, then a compare of the two products
// depends on tpl_pkg for the status struct
module tpl_cross_unit import tpl_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [CW-1:0] p_x,
	input  logic signed [CW-1:0] p_y,
	input  logic signed [CW-1:0] q_x,
	input  logic signed [CW-1:0] q_y,
	input  logic signed [CW-1:0] r_x,
	input  logic signed [CW-1:0] r_y,
	output tpl_cross_stat_t      stat
);

	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;

	typedef enum logic [1:0] {PH_IDLE, PH_MUL_A, PH_MUL_B, PH_CMP} phase_t;

	phase_t               phase_q;
	logic signed [DW-1:0] ax, ay, bx, by;
	logic signed [DW-1:0] mul_l, mul_r;
	logic signed [PW-1:0] product;
	logic signed [PW-1:0] prod_a_q, prod_b_q;

	// operand differences, exact in one extra bit
	assign ax = DW'(p_x) - DW'(r_x);
	assign ay = DW'(p_y) - DW'(r_y);
	assign bx = DW'(q_x) - DW'(r_x);
	assign by = DW'(q_y) - DW'(r_y);

	// shared multiplier operand select
	always_comb begin
		case (phase_q)
			PH_MUL_B: begin
				mul_l = bx;
				mul_r = ay;
			end
			default: begin
				mul_l = ax;
				mul_r = by;
			end
		endcase
	end

	assign product = mul_l * mul_r;

	// phase sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE:  phase_q <= start ? PH_MUL_A : PH_IDLE;
				PH_MUL_A: phase_q <= PH_MUL_B;
				PH_MUL_B: phase_q <= PH_CMP;
				default:  phase_q <= PH_IDLE;
			endcase
		end
	end

	// product registers
	always_ff @(posedge clk) begin
		if (phase_q == PH_MUL_A) begin
			prod_a_q <= product;
		end
		if (phase_q == PH_MUL_B) begin
			prod_b_q <= product;
		end
	end

	// sign of ax*by - bx*ay
	assign stat.done = (phase_q == PH_CMP);
	assign stat.neg  = (prod_a_q < prod_b_q);
	assign stat.pos  = (prod_a_q > prod_b_q);

endmodule

// ===== src/triangle_point_locate.sv =====
// triangle_point_locate: point in triangle search over a stored mesh
// uses tpl_pkg, the three channel interfaces and tpl_cross_unit
//
// Channels: in_item takes load and query items, result gives one item per
// query, cfg writes triangle_count (always ready). Modes: load vertex writes
// x/y at slot, load triangle writes three corner indices at slot, query
// searches triangles 0 to min(count, MAX_TRIANGLES)-1 and returns the first
// one that holds the point (edges count as inside), or found = 0 with index 0.
// Loads may follow back to back. A query holds in_item.ready low while it
// runs: for each triangle tested, a triangle memory read, a vertex memory read
// per corner and an edge sign per edge on the one shared multiplier; a final
// count check when no triangle holds the point; then the load of the
// result register. The next item is taken in the cycle after that load.
// The result sits in an output register; if the receiver stalls, the next
// query finishes its search and then waits until the register is taken.
// Reset clears the count, the state and the output register; vertex and
// triangle memories are not cleared and must be written before use.
module triangle_point_locate import tpl_pkg::*; #(
	parameter int MAX_VERTICES  = 256,
	parameter int MAX_TRIANGLES = 256,
	parameter int COORD_WIDTH   = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	tpl_item_if.sink     in_item,
	tpl_result_if.source result,
	tpl_cfg_if.sink      cfg
);

	localparam int CE   = (COORD_WIDTH < COORD_W) ? COORD_WIDTH : COORD_W;
	localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int TA_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int TI_W = $clog2(MAX_TRIANGLES + 1);
	localparam int TW   = 3 * CORNER_W;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_TRI, S_VTX, S_EDGE, S_WAIT, S_FINISH
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   count_q;
	logic [TI_W-1:0]      n_q, i_q;
	logic [1:0]           c_q, e_q;
	logic                 neg_q, pos_q, hit_q;
	logic signed [CE-1:0] pt_x_q, pt_y_q;
	logic signed [CE-1:0] va_x_q, va_y_q, vb_x_q, vb_y_q, vc_x_q, vc_y_q;
	logic                 res_valid_q, res_found_q;
	logic [TIDX_W-1:0]    res_idx_q;

	logic [2*CE-1:0]      vtx_mem [MAX_VERTICES];
	logic [TW-1:0]        tri_mem [MAX_TRIANGLES];
	logic [2*CE-1:0]      vtx_rd_q;
	logic [TW-1:0]        tri_rd_q;
	logic                 rng_q;

	logic                 accept;
	logic [31:0]          slot_w, corner_w, count_w, idx_w;
	logic                 vtx_we, tri_we;
	logic [CORNER_W-1:0]  corner;
	logic [2*CE-1:0]      vtx_val;
	logic signed [CE-1:0] q_x, q_y, r_x, r_y;
	logic                 start;
	tpl_cross_stat_t      stat;
	logic                 neg_all, pos_all;

	assign accept  = in_item.valid && in_item.ready;
	assign slot_w  = 32'(in_item.slot);
	assign count_w = 32'(count_q);
	assign idx_w   = 32'(i_q);
	assign vtx_we  = accept && (in_item.mode == MODE_LOAD_VERTEX) && (slot_w < MAX_VERTICES);
	assign tri_we  = accept && (in_item.mode == MODE_LOAD_TRIANGLE) && (slot_w < MAX_TRIANGLES);

	// handshakes
	assign in_item.ready         = (state_q == S_IDLE);
	assign cfg.ready             = 1'b1;
	assign result.valid          = res_valid_q;
	assign result.found          = res_found_q;
	assign result.triangle_index = res_idx_q;

	// corner index of the current triangle
	always_comb begin
		case (c_q)
			2'd0:    corner = tri_rd_q[CORNER_W-1:0];
			2'd1:    corner = tri_rd_q[2*CORNER_W-1:CORNER_W];
			default: corner = tri_rd_q[3*CORNER_W-1:2*CORNER_W];
		endcase
	end
	assign corner_w = 32'(corner);

	// triangle memory
	always_ff @(posedge clk) begin
		if (tri_we) begin
			tri_mem[slot_w[TA_W-1:0]] <= {in_item.corner_c, in_item.corner_b, in_item.corner_a};
		end
		tri_rd_q <= tri_mem[i_q[TA_W-1:0]];
	end

	// vertex memory, out of range corners read as the origin
	always_ff @(posedge clk) begin
		if (vtx_we) begin
			vtx_mem[slot_w[VA_W-1:0]] <= {in_item.coord_y[CE-1:0], in_item.coord_x[CE-1:0]};
		end
		vtx_rd_q <= vtx_mem[corner_w[VA_W-1:0]];
		rng_q    <= (corner_w < MAX_VERTICES);
	end
	assign vtx_val = rng_q ? vtx_rd_q : '0;

	// edge operands: (a,b), (b,c), (c,a)
	always_comb begin
		case (e_q)
			2'd0: begin
				q_x = va_x_q; q_y = va_y_q; r_x = vb_x_q; r_y = vb_y_q;
			end
			2'd1: begin
				q_x = vb_x_q; q_y = vb_y_q; r_x = vc_x_q; r_y = vc_y_q;
			end
			default: begin
				q_x = vc_x_q; q_y = vc_y_q; r_x = va_x_q; r_y = va_y_q;
			end
		endcase
	end

	assign start = (state_q == S_EDGE);

	tpl_cross_unit #(
		.CW (CE)
	) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.p_x    (pt_x_q),
		.p_y    (pt_y_q),
		.q_x    (q_x),
		.q_y    (q_y),
		.r_x    (r_x),
		.r_y    (r_y),
		.stat   (stat)
	);

	assign neg_all = neg_q | stat.neg;
	assign pos_all = pos_q | stat.pos;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			count_q <= cfg.data;
		end
	end

	// search sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			i_q         <= '0;
			c_q         <= '0;
			e_q         <= '0;
			neg_q       <= 1'b0;
			pos_q       <= 1'b0;
			hit_q       <= 1'b0;
			pt_x_q      <= '0;
			pt_y_q      <= '0;
			va_x_q      <= '0;
			va_y_q      <= '0;
			vb_x_q      <= '0;
			vb_y_q      <= '0;
			vc_x_q      <= '0;
			vc_y_q      <= '0;
			res_valid_q <= 1'b0;
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
		end else begin
			// result taken and no new one loaded this cycle
			if (res_valid_q && result.ready && (state_q != S_FINISH)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (in_item.mode == MODE_QUERY)) begin
						pt_x_q  <= in_item.coord_x[CE-1:0];
						pt_y_q  <= in_item.coord_y[CE-1:0];
						i_q     <= '0;
						n_q     <= (count_w > MAX_TRIANGLES) ? TI_W'(MAX_TRIANGLES)
							: TI_W'(count_w);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (i_q < n_q) begin
						c_q     <= '0;
						state_q <= S_TRI;
					end else begin
						hit_q   <= 1'b0;
						state_q <= S_FINISH;
					end
				end
				S_TRI: begin
					state_q <= S_VTX;
				end
				S_VTX: begin
					case (c_q)
						2'd0: begin
							va_x_q <= vtx_val[CE-1:0];
							va_y_q <= vtx_val[2*CE-1:CE];
						end
						2'd1: begin
							vb_x_q <= vtx_val[CE-1:0];
							vb_y_q <= vtx_val[2*CE-1:CE];
						end
						default: begin
							vc_x_q <= vtx_val[CE-1:0];
							vc_y_q <= vtx_val[2*CE-1:CE];
						end
					endcase
					if (c_q == 2'd2) begin
						e_q     <= '0;
						neg_q   <= 1'b0;
						pos_q   <= 1'b0;
						state_q <= S_EDGE;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_TRI;
					end
				end
				S_EDGE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (stat.done) begin
						neg_q <= neg_all;
						pos_q <= pos_all;
						if (e_q != 2'd2) begin
							e_q     <= e_q + 2'd1;
							state_q <= S_EDGE;
						end else if (!(neg_all && pos_all)) begin
							hit_q   <= 1'b1;
							state_q <= S_FINISH;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_FINISH: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_found_q <= hit_q;
						res_idx_q   <= hit_q ? idx_w[TIDX_W-1:0] : '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a hit is only reported for a triangle inside the searched range
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT && stat.done && e_q == 2'd2) |-> (i_q < n_q))
		else $error("hit test beyond triangle count");

	// the sign unit only finishes while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == S_WAIT))
		else $error("sign unit done outside wait state");

	// a new result is loaded only from the finish state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result appeared without a finished query");

	// a miss always carries index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_found_q) |-> (res_idx_q == '0))
		else $error("not found result with nonzero index");

	// no item is taken while a query is running
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT || state_q == S_SCAN) |=> !accept || state_q == S_IDLE)
		else $error("item accepted during search");

endmodule
